### rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Shared constants, codes, types and sizing functions of the size-class
// block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

  // Field widths of the request, response and configuration payloads.
  localparam int unsigned CMD_W     = 1;
  localparam int unsigned SIZE_W    = 24;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CLASS_W   = 6;
  localparam int unsigned USED_W    = 21;

  // Rounded sizes up to the largest class fit in 13 bits.
  localparam int unsigned ESIZE_W   = 13;
  localparam int unsigned NUM_CLASSES = 44;
  localparam int unsigned LARGEST_REQ_SIZE = 7168;

  // Byte addresses are 20 bits, so at most 2^17 distinct 8-byte words.
  localparam int unsigned MAX_WORD_W     = 17;
  localparam int unsigned MAX_LINK_WORDS = 1 << MAX_WORD_W;
  localparam int unsigned ADDR_SPACE     = 1 << ADDR_W;

  localparam int unsigned POOL_BYTES_DEF = 1048576;
  localparam int unsigned POOL_LIMIT_RST = 1048576;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_MEM    = 2'd2;

  // Decoded request size.
  typedef struct packed {
    logic               too_large;
    logic [ESIZE_W-1:0] esize;
    logic [CLASS_W-1:0] cls;
  } class_info_t;

  // Number of link store entries that can ever be addressed.
  function automatic int unsigned link_depth(int unsigned pool_bytes);
    int unsigned words;
    words = pool_bytes >> 3;
    return (words < MAX_LINK_WORDS) ? words : MAX_LINK_WORDS;
  endfunction

  // True when a freed word index must be reduced by a non power of two.
  function automatic bit need_mod(int unsigned pool_bytes);
    int unsigned words;
    words = pool_bytes >> 3;
    return (words < MAX_LINK_WORDS) && ((words & (words - 1)) != 0);
  endfunction

endpackage

`default_nettype wire

### rtl/sca_req_if.sv
// ----------------------------------------------------------------------------
// sca_req_if
// Request channel: allocate or free command with size and block address.
// ----------------------------------------------------------------------------
`default_nettype none

interface sca_req_if;
  import sca_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, output command, output request_size,
                  output block_address, input ready);
  modport sink   (input valid, input command, input request_size,
                  input block_address, output ready);
endinterface

`default_nettype wire

### rtl/sca_rsp_if.sv
// ----------------------------------------------------------------------------
// sca_rsp_if
// Response channel: status, granted address, class and pool usage.
// ----------------------------------------------------------------------------
`default_nettype none

interface sca_rsp_if;
  import sca_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   granted_address;
  logic [CLASS_W-1:0]  size_class;
  logic [USED_W-1:0]   used_bytes;

  modport source (output valid, output status, output granted_address,
                  output size_class, output used_bytes, input ready);
  modport sink   (input valid, input status, input granted_address,
                  input size_class, input used_bytes, output ready);
endinterface

`default_nettype wire

### rtl/sca_cfg_if.sv
// ----------------------------------------------------------------------------
// sca_cfg_if
// Configuration write channel for the pool limit register.
// ----------------------------------------------------------------------------
`default_nettype none

interface sca_cfg_if;
  import sca_pkg::*;

  logic              valid;
  logic              ready;
  logic [USED_W-1:0] pool_limit_bytes;

  modport source (output valid, output pool_limit_bytes, input ready);
  modport sink   (input valid, input pool_limit_bytes, output ready);
endinterface

`default_nettype wire

### rtl/sca_ram.sv
// ----------------------------------------------------------------------------
// sca_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_ram #(
  parameter int unsigned DEPTH = sca_pkg::NUM_CLASSES,
  parameter int unsigned WIDTH = sca_pkg::MAX_WORD_W,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/sca_size_class.sv
// ----------------------------------------------------------------------------
// sca_size_class
// Rounds a request size up to 8 bytes and maps it to its size class.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_size_class (
  input  logic [sca_pkg::SIZE_W-1:0] size_i,
  output sca_pkg::class_info_t       info_o
);
  import sca_pkg::*;

  logic                 too_large;
  logic [ESIZE_W-1:0]   esize;
  logic [3:0]           lead;
  logic [1:0]           frac;
  logic [CLASS_W-1:0]   cls;

  assign too_large = size_i > SIZE_W'(LARGEST_REQ_SIZE);
  assign esize     = ESIZE_W'({1'b0, size_i[ESIZE_W-1:0]} + (ESIZE_W + 1)'(7))
                     & ~ESIZE_W'(7);

  // The class is the leading-one position and the two bits below it, less 8.
  always_comb begin
    lead = 4'd0;
    for (int b = 3; b < ESIZE_W; b++) begin
      if (esize[b]) begin
        lead = 4'(b);
      end
    end
    frac = 2'(esize >> (lead - 4'd2));
    if (too_large || (esize == '0)) begin
      cls = '0;
    end else begin
      cls = CLASS_W'({lead, frac}) - CLASS_W'(8);
    end
  end

  assign info_o.too_large = too_large;
  assign info_o.esize     = esize;
  assign info_o.cls       = cls;

endmodule

`default_nettype wire

### rtl/sca_word_map.sv
// ----------------------------------------------------------------------------
// sca_word_map
// Reduces the word index of a freed address modulo the pool word count.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_word_map #(
  parameter int unsigned POOL_BYTES = sca_pkg::POOL_BYTES_DEF,
  localparam int unsigned WW = $clog2(sca_pkg::link_depth(POOL_BYTES))
) (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [sca_pkg::MAX_WORD_W-1:0] addr_word_i,
  output logic [WW-1:0]                  word_o
);
  import sca_pkg::*;

  localparam int unsigned LINK_WORDS = POOL_BYTES >> 3;

  logic [WW-1:0] word_q;

  if (need_mod(POOL_BYTES)) begin : g_mod
    // Quotient by reciprocal multiplication; it is low by at most one,
    // so the remainder needs a single correcting subtract.
    localparam int unsigned SH      = MAX_WORD_W + $clog2(LINK_WORDS);
    localparam int unsigned RECIP_W = MAX_WORD_W + 1;
    localparam int unsigned PROD_W  = MAX_WORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0]    RECIP = RECIP_W'((64'd1 << SH) / LINK_WORDS);
    localparam logic [MAX_WORD_W-1:0] LW    = MAX_WORD_W'(LINK_WORDS);

    logic [MAX_WORD_W-1:0]   v_q;
    logic [MAX_WORD_W-1:0]   quot_q;
    logic [PROD_W-1:0]       recip_prod;
    logic [2*MAX_WORD_W-1:0] back_prod;
    logic [MAX_WORD_W-1:0]   rem_raw;

    assign recip_prod = PROD_W'(addr_word_i) * PROD_W'(RECIP);
    assign back_prod  = (2*MAX_WORD_W)'(quot_q) * (2*MAX_WORD_W)'(LW);
    assign rem_raw    = v_q - back_prod[MAX_WORD_W-1:0];

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        v_q    <= addr_word_i;
        quot_q <= MAX_WORD_W'(recip_prod >> SH);
      end
      if (step_i) begin
        word_q <= (rem_raw >= LW) ? WW'(rem_raw - LW) : WW'(rem_raw);
      end
    end
  end else begin : g_mask
    // Power-of-two word count, or a pool that covers every word: the remainder is the low bits.
    always_ff @(posedge clk_i) begin
      if (load_i || step_i) begin
        word_q <= addr_word_i[WW-1:0];
      end
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

### rtl/size_class_block_allocator_top.sv
// ----------------------------------------------------------------------------
// size_class_block_allocator_top
// Segregated free-list allocator: 44 size classes over a bump pool, with
// list heads and per-word next links held in synchronous RAMs.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                                          Ready
//   req_i    in   command, request_size, block_address             idle only
//   rsp_o    out  status, granted_address, size_class, used_bytes  from sink
//   cfg_i    in   pool_limit_bytes                                 always
//
// A free or a bump allocation finishes in S_HEAD; a pop from a class list goes
// on to S_LINK: the head RAM read, then the link RAM read at the head's word.
// Every request passes through S_MAP before S_HEAD when the pool word count is
// below 2^17 and not a power of two (remainder stage). Reset clears the list valid
// flops and the bump pointer at once; the link RAM is not cleared. A finished
// response waits in the output register while the next request is taken; only
// the final state stalls until the response slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module size_class_block_allocator_top #(
  parameter int unsigned POOL_BYTES = sca_pkg::POOL_BYTES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  sca_req_if.sink      req_i,
  sca_rsp_if.source    rsp_o,
  sca_cfg_if.sink      cfg_i
);
  import sca_pkg::*;

  localparam int unsigned LINK_DEPTH = link_depth(POOL_BYTES);
  localparam int unsigned WORD_W     = $clog2(LINK_DEPTH);
  localparam bit          NEED_MOD   = need_mod(POOL_BYTES);
  localparam logic [USED_W-1:0] LIMIT_CAP =
      USED_W'((POOL_BYTES < ADDR_SPACE) ? POOL_BYTES : ADDR_SPACE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAP  = 2'd1;
  localparam logic [1:0] S_HEAD = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CMD_W-1:0]       cmd_q;
  class_info_t            info, info_q;
  logic [NUM_CLASSES-1:0] head_valid_q, head_valid_d;
  logic [USED_W-1:0]      bump_q, bump_d;
  logic [USED_W-1:0]      cfg_q;
  logic [USED_W-1:0]      eff_limit;
  logic [USED_W:0]        bump_sum;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [ADDR_W-1:0]      granted_q;
  logic [CLASS_W-1:0]     cls_out_q;
  logic [USED_W-1:0]      used_q;

  logic                   accept, out_free, done;
  logic [STATUS_W-1:0]    res_status;
  logic [ADDR_W-1:0]      res_granted;

  logic                   head_we;
  logic [WORD_W-1:0]      head_wdata, head_rdata;
  logic                   head_valid_cur;
  logic                   link_re, link_we;
  logic [WORD_W:0]        link_rdata;
  logic                   map_step;
  logic [WORD_W-1:0]      map_word;

  assign accept    = req_i.valid && req_i.ready;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign eff_limit      = (cfg_q < LIMIT_CAP) ? cfg_q : LIMIT_CAP;
  assign bump_sum       = {1'b0, bump_q} + (USED_W + 1)'(info_q.esize);
  assign head_valid_cur = head_valid_q[info_q.cls];

  sca_size_class u_size_class (
    .size_i (req_i.request_size),
    .info_o (info)
  );

  sca_word_map #(
    .POOL_BYTES (POOL_BYTES)
  ) u_word_map (
    .clk_i       (clk_i),
    .load_i      (accept),
    .step_i      (map_step),
    .addr_word_i (req_i.block_address[ADDR_W-1:3]),
    .word_o      (map_word)
  );

  // Class list heads; the valid bit of each head lives in head_valid_q.
  sca_ram #(
    .DEPTH (NUM_CLASSES),
    .WIDTH (WORD_W)
  ) u_head_ram (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (info.cls),
    .rd_data_o (head_rdata),
    .wr_en_i   (head_we),
    .wr_addr_i (info_q.cls),
    .wr_data_i (head_wdata)
  );

  // Next links, one per pool word: the previous head including its valid bit.
  sca_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (WORD_W + 1)
  ) u_link_ram (
    .clk_i     (clk_i),
    .rd_en_i   (link_re),
    .rd_addr_i (head_rdata),
    .rd_data_o (link_rdata),
    .wr_en_i   (link_we),
    .wr_addr_i (map_word),
    .wr_data_i ({head_valid_cur, head_rdata})
  );

  always_comb begin
    state_d      = state_q;
    bump_d       = bump_q;
    head_valid_d = head_valid_q;
    head_we      = 1'b0;
    head_wdata   = map_word;
    link_re      = 1'b0;
    link_we      = 1'b0;
    map_step     = 1'b0;
    done         = 1'b0;
    res_status   = STATUS_DONE;
    res_granted  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = NEED_MOD ? S_MAP : S_HEAD;
        end
      end
      S_MAP: begin
        map_step = 1'b1;
        state_d  = S_HEAD;
      end
      S_HEAD: begin
        if (info_q.too_large) begin
          if (out_free) begin
            done       = 1'b1;
            res_status = STATUS_TOO_LARGE;
            state_d    = S_IDLE;
          end
        end else if (cmd_q == CMD_FREE) begin
          if (out_free) begin
            link_we                  = 1'b1;
            head_we                  = 1'b1;
            head_valid_d[info_q.cls] = 1'b1;
            done                     = 1'b1;
            state_d                  = S_IDLE;
          end
        end else if (head_valid_cur) begin
          link_re = 1'b1;
          state_d = S_LINK;
        end else if (out_free) begin
          done    = 1'b1;
          state_d = S_IDLE;
          if (bump_sum <= {1'b0, eff_limit}) begin
            res_granted = bump_q[ADDR_W-1:0];
            bump_d      = bump_sum[USED_W-1:0];
          end else begin
            res_status = STATUS_NO_MEM;
          end
        end
      end
      S_LINK: begin
        if (out_free) begin
          head_we                  = 1'b1;
          head_wdata               = link_rdata[WORD_W-1:0];
          head_valid_d[info_q.cls] = link_rdata[WORD_W];
          res_granted              = ADDR_W'({head_rdata, 3'b000});
          done                     = 1'b1;
          state_d                  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_valid_q <= '0;
      bump_q       <= '0;
      cfg_q        <= USED_W'(POOL_LIMIT_RST);
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_valid_q <= head_valid_d;
      bump_q       <= bump_d;
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.pool_limit_bytes;
      end
      out_valid_q  <= done || (out_valid_q && !rsp_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.command;
      info_q <= info;
    end
    if (done) begin
      status_q  <= res_status;
      granted_q <= res_granted;
      cls_out_q <= info_q.cls;
      used_q    <= bump_d;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.granted_address = granted_q;
  assign rsp_o.size_class      = cls_out_q;
  assign rsp_o.used_bytes      = used_q;

`ifndef NO_ASSERTIONS
  // Bump allocation never carries the pointer past the effective limit.
  a_bump_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_d != bump_q) |=> (bump_q <= $past(eff_limit)))
    else $error("bump pointer moved past the pool limit");

  // Both list heads and bump offsets are 8-byte aligned.
  a_grant_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (granted_q[2:0] == 3'b000))
    else $error("granted address is not 8-byte aligned");

  // An oversized request leaves no class and no address behind.
  a_too_large_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q == STATUS_TOO_LARGE)) |->
    ((granted_q == '0) && (cls_out_q == '0)))
    else $error("too-large response carries a class or an address");

  // A link read is issued only for a pop and is consumed in the next state.
  a_link_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_re |=> ((state_q == S_LINK) && $past(head_valid_cur)
                 && ($past(cmd_q) == CMD_ALLOC)))
    else $error("link read without a pop of a valid head");
`endif

endmodule

`default_nettype wire
